// ===== design/gpdt_pkg.sv =====
// Shared register indexes and field widths for the grid point dedup table.
package gpdt_pkg;
  localparam int COORD_W = 48;
  localparam int SCALE_W = 32;
  localparam int INDEX_W = 24;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_CAND = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SCALE = 8'd0,
    REG_INDEX_BASE = 8'd1
  } reg_idx_t;
endpackage

// ===== design/grid_point_dedup_table.sv =====
// Top level of the grid point dedup table: key quantizer, table scan and insert.
// Usage: points arrive on the input channel (in_valid/in_ready) as a mode bit
// and three signed Q31.16 coordinates. Each point yields exactly one result
// transaction on the output channel (out_valid/out_ready): the point index,
// a new-entry flag, a table-full flag and a key-clamp flag.
// Registers cell_scale (index 0) and index_base (index 1) are written through
// the configuration channel (cfg_valid/cfg_ready, always ready); the user must
// write them only while idle, as the block itself does not enforce it. The
// three axis keys are formed with the multiply step shared by the axes (a
// multiply state and an add/clamp state per axis). The key memory is then
// scanned one entry per cycle over the filled entries, all eight candidate
// cells compared at once on the registered read data, and a finishing state
// inserts and posts the result; the single read port sets the pace of the scan.
// One point is processed at a time; the next point is accepted once the
// previous one has posted its result into the output register, even if that
// result still waits for the receiver. A stalled receiver holds the result
// in the output register and stops the next point at its finishing cycle.
// Reset empties the table (the fill count is cleared, so no clearing pass
// is needed) and restores the register reset values.
module grid_point_dedup_table
  import gpdt_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_AXIS_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [INDEX_W-1:0]        point_index,
  output logic                      is_new,
  output logic                      table_full,
  output logic                      key_clamped,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KB = KEY_AXIS_BITS;
  localparam int KEY_W = 3 * KB;
  localparam int PA_W = 65;
  localparam int PB_W = 48;
  localparam int SUM_W = 81;
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(TABLE_DEPTH);
  localparam logic signed [COORD_W-1:0] KMIN = -(48'sd1 <<< (KB - 1));
  localparam logic signed [COORD_W-1:0] KMAX = (48'sd1 <<< (KB - 1)) - 48'sd1;
  localparam logic [KB-1:0] AXIS_MIN = {1'b1, {(KB - 1){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_SCAN, S_FIN} state_t;

  state_t state;
  logic [SCALE_W-1:0] cell_scale;
  logic [INDEX_W-1:0] index_base;

  logic mode_q;
  logic signed [COORD_W-1:0] crd [3];
  logic [1:0] axis;
  logic signed [PA_W-1:0] prod_a;
  logic [PB_W-1:0] prod_b;
  logic [KB-1:0] key [3];
  logic clamp_q;

  logic [KEY_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W-1:0] mem_q;
  logic [AW:0] count;
  logic [AW:0] iss;
  logic rd_en;
  logic pend;
  logic [AW-1:0] pslot;

  logic [NUM_CAND-1:0] hit;
  logic [AW-1:0] hslot [NUM_CAND];
  logic [KEY_W-1:0] cand [NUM_CAND];
  logic [NUM_CAND-1:0] cand_en;

  logic signed [COORD_W-1:0] cur;
  logic signed [SUM_W-1:0] sum;
  logic signed [COORD_W-1:0] kf;

  logic found;
  logic [AW-1:0] fslot;
  logic fin_go;
  logic wr_en;
  logic [INDEX_W:0] idx_sum;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cur = crd[axis];

  // Full Q47.32 product, with the half-unit rounding term in cluster mode.
  always_comb begin
    sum = (SUM_W'(prod_a) <<< 16) + $signed({33'b0, prod_b})
        + (mode_q ? $signed(SUM_W'(64'h8000_0000)) : $signed(SUM_W'(0)));
    kf = sum[79:32];
  end

  // Candidate cells: the primary cell, then (cluster mode) every mix of key-1
  // and key per axis, x, y, z ascending. A cell below the key range is disabled.
  always_comb begin
    cand[0] = {key[2], key[1], key[0]};
    cand_en[0] = 1'b1;
    for (int n = 0; n < NUM_CAND - 1; n++) begin
      logic [KB-1:0] ax [3];
      logic ok;
      ok = mode_q;
      for (int a = 0; a < 3; a++) begin
        if (n[2 - a]) begin
          ax[a] = key[a];
        end else begin
          ax[a] = key[a] - KB'(1);
          if (key[a] == AXIS_MIN) ok = 1'b0;
        end
      end
      cand[n + 1] = {ax[2], ax[1], ax[0]};
      cand_en[n + 1] = ok;
    end
  end

  always_comb begin
    found = 1'b0;
    fslot = '0;
    for (int j = NUM_CAND - 1; j >= 0; j--) begin
      if (hit[j]) begin
        found = 1'b1;
        fslot = hslot[j];
      end
    end
  end

  assign rd_en = (state == S_SCAN) && (iss < count);
  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);
  assign wr_en = fin_go && !found && (count < DEPTH_C);
  // Index base plus the matched slot, or plus the slot that a new entry takes.
  assign idx_sum = {1'b0, index_base} + (INDEX_W + 1)'(found ? fslot : count[AW-1:0]);

  // Key memory: one synchronous read port, one write port.
  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[iss[AW-1:0]];
    if (wr_en) mem[count[AW-1:0]] <= cand[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cell_scale <= 32'd65536;
      index_base <= '0;
      count <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
      hit <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CELL_SCALE: cell_scale <= cfg_data;
          REG_INDEX_BASE: index_base <= cfg_data[INDEX_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && !fin_go) out_valid <= 1'b0;
      pend <= rd_en;
      pslot <= iss[AW-1:0];
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            crd[0] <= coord_x;
            crd[1] <= coord_y;
            crd[2] <= coord_z;
            axis <= 2'd0;
            clamp_q <= 1'b0;
            hit <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_a <= $signed(cur[47:16]) * $signed({1'b0, cell_scale});
          prod_b <= PB_W'(cur[15:0]) * PB_W'(cell_scale);
          state <= S_ADD;
        end
        S_ADD: begin
          if (kf < KMIN) begin
            key[axis] <= KMIN[KB-1:0];
            clamp_q <= 1'b1;
          end else if (kf > KMAX) begin
            key[axis] <= KMAX[KB-1:0];
            clamp_q <= 1'b1;
          end else begin
            key[axis] <= kf[KB-1:0];
          end
          if (axis == 2'd2) begin
            iss <= '0;
            state <= S_SCAN;
          end else begin
            axis <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_SCAN: begin
          if (rd_en) iss <= iss + (AW + 1)'(1);
          if (pend) begin
            for (int j = 0; j < NUM_CAND; j++) begin
              if (cand_en[j] && mem_q == cand[j]) begin
                hit[j] <= 1'b1;
                hslot[j] <= pslot;
              end
            end
          end
          if (!rd_en && !pend) state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            key_clamped <= clamp_q;
            if (found) begin
              point_index <= idx_sum[INDEX_W] ? {INDEX_W{1'b1}} : idx_sum[INDEX_W-1:0];
              is_new <= 1'b0;
              table_full <= 1'b0;
            end else if (count < DEPTH_C) begin
              point_index <= idx_sum[INDEX_W] ? {INDEX_W{1'b1}} : idx_sum[INDEX_W-1:0];
              is_new <= 1'b1;
              table_full <= 1'b0;
              count <= count + (AW + 1)'(1);
            end else begin
              point_index <= '0;
              is_new <= 1'b0;
              table_full <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("fill count beyond table depth");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && table_full))
    else $error("new and full flags both set");
  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (point_index == '0))
    else $error("full result carries a nonzero index");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (out_valid && is_new))
    else $error("fill count moved without an insert");
`endif
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the grid point dedup table top level.
module tb
  import gpdt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int AXIS_BITS = 20;
  localparam int KEY_W = 3 * AXIS_BITS;
  localparam longint KEY_LIM = 64'sd1 << (AXIS_BITS - 1);
  localparam int INDEX_MAX = 24'hFFFFFF;
  localparam int CYCLE_LIMIT = 10000000;
  // Register index that the block does not decode; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;
  localparam logic MODE_EXACT = 1'b0;
  localparam logic MODE_CLUSTER = 1'b1;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] ONE_UNIT = 48'sd65536;

  typedef struct packed {
    logic [INDEX_W-1:0] point_index;
    logic               is_new;
    logic               table_full;
    logic               key_clamped;
  } weld_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_W-1:0] point_index;
  logic is_new;
  logic table_full;
  logic key_clamped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's state and registers.
  logic [KEY_W-1:0] stored_keys[$];
  logic [SCALE_W-1:0] shadow_scale = 32'd65536;
  logic [INDEX_W-1:0] shadow_base = '0;
  weld_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int error_count = 0;
  int points_sent = 0;
  int results_checked = 0;
  int new_entries_seen = 0;
  int full_seen = 0;
  int clamp_seen = 0;
  int cycle_count = 0;

  grid_point_dedup_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_index(point_index), .is_new(is_new),
    .table_full(table_full), .key_clamped(key_clamped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // The watchdog ends a hung run; the limit is several times the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("grid_point_dedup_table verification failed");
      $finish;
    end
  end

  // Quantizes one coordinate into a grid cell: an exact product, a floor or a
  // round-half-up, then a clamp to the signed key range of one axis.
  function automatic longint quantize_axis(input logic signed [COORD_W-1:0] c,
                                           input logic round_half, inout logic clamped);
    logic signed [81:0] prod;
    logic signed [81:0] grid_k;
    longint k;
    prod = c * $signed({1'b0, shadow_scale});
    if (round_half) begin
      prod = prod + (82'sd1 <<< 31);
    end
    grid_k = prod >>> 32;
    if (grid_k < -82'sd524288) begin
      k = -KEY_LIM;
      clamped = 1'b1;
    end else if (grid_k > 82'sd524287) begin
      k = KEY_LIM - 1;
      clamped = 1'b1;
    end else begin
      k = longint'(grid_k);
    end
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pack_cell(input longint kx, input longint ky,
                                                 input longint kz);
    logic [AXIS_BITS-1:0] bx, by, bz;
    bx = kx[AXIS_BITS-1:0];
    by = ky[AXIS_BITS-1:0];
    bz = kz[AXIS_BITS-1:0];
    return {bz, by, bx};
  endfunction

  // Entries are searched in insertion order; the first equal key wins.
  function automatic int find_cell(input logic [KEY_W-1:0] key);
    foreach (stored_keys[i]) begin
      if (stored_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Welds one accepted point into the shadow table and returns its result.
  function automatic weld_result_t weld_point(input logic m, input logic signed [COORD_W-1:0] x,
                                              input logic signed [COORD_W-1:0] y,
                                              input logic signed [COORD_W-1:0] z);
    weld_result_t r;
    logic clamped;
    longint kx, ky, kz, nx, ny, nz;
    int slot;
    longint idx;
    clamped = 1'b0;
    r = '0;
    kx = quantize_axis(x, m, clamped);
    ky = quantize_axis(y, m, clamped);
    kz = quantize_axis(z, m, clamped);
    slot = find_cell(pack_cell(kx, ky, kz));
    if (slot < 0 && m == MODE_CLUSTER) begin
      // The seven lower neighbours, x slowest; neighbours below the key range are skipped.
      for (int dx = -1; dx <= 0 && slot < 0; dx++)
        for (int dy = -1; dy <= 0 && slot < 0; dy++)
          for (int dz = -1; dz <= 0 && slot < 0; dz++) begin
            nx = kx + dx;
            ny = ky + dy;
            nz = kz + dz;
            if (!(dx == 0 && dy == 0 && dz == 0) &&
                nx >= -KEY_LIM && ny >= -KEY_LIM && nz >= -KEY_LIM) begin
              slot = find_cell(pack_cell(nx, ny, nz));
            end
          end
    end
    if (slot < 0) begin
      if (stored_keys.size() < DEPTH) begin
        slot = stored_keys.size();
        stored_keys = {stored_keys, pack_cell(kx, ky, kz)};
        r.is_new = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    if (slot >= 0) begin
      idx = longint'(shadow_base) + slot;
      r.point_index = (idx > INDEX_MAX) ? {INDEX_W{1'b1}} : idx[INDEX_W-1:0];
    end
    r.key_clamped = clamped;
    return r;
  endfunction

  // Result checker and receiver stall generator in one process: the sample is
  // taken before this edge's new ready value is scheduled.
  always @(posedge clk) begin
    weld_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("Result transaction with no point outstanding: index %0d", point_index);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (point_index !== exp_r.point_index) begin
          $error("point_index expected %0d got %0d", exp_r.point_index, point_index);
          error_count++;
        end
        if (is_new !== exp_r.is_new) begin
          $error("is_new expected %0b got %0b", exp_r.is_new, is_new);
          error_count++;
        end
        if (table_full !== exp_r.table_full) begin
          $error("table_full expected %0b got %0b", exp_r.table_full, table_full);
          error_count++;
        end
        if (key_clamped !== exp_r.key_clamped) begin
          $error("key_clamped expected %0b got %0b", exp_r.key_clamped, key_clamped);
          error_count++;
        end
        new_entries_seen += exp_r.is_new;
        full_seen += exp_r.table_full;
        clamp_seen += exp_r.key_clamped;
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one point and returns at the edge where the transaction happens.
  // Valid stays high into the next call unless that call opens a gap first.
  task automatic send_point(input logic m, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    mode <= m;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, weld_point(m, x, y, z)};
    points_sent++;
  endtask

  // Waits until every result has arrived, then for one full scan of the table.
  task automatic wait_idle();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (stored_keys.size() + 16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CELL_SCALE) shadow_scale = val;
    else if (idx == REG_INDEX_BASE) shadow_base = val[INDEX_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] random_coord();
    return COORD_W'({$urandom(), $urandom()});
  endfunction

  // A coordinate near a small set of grid cells, so points weld often and the
  // table stays small; the fraction lands anywhere in the cell.
  function automatic logic signed [COORD_W-1:0] cluster_coord();
    logic signed [COORD_W-1:0] c;
    c = $signed(48'($urandom_range(4))) - 48'sd2;
    return c * ONE_UNIT + $signed({32'd0, 16'($urandom())});
  endfunction

  task automatic test_directed();
    send_point(MODE_EXACT, '0, '0, '0);
    send_point(MODE_EXACT, '0, '0, '0);
    send_point(MODE_EXACT, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(MODE_EXACT, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(MODE_CLUSTER, COORD_MIN, COORD_MIN, COORD_MIN);
    // Exactly half a cell rounds up, both above and below zero.
    send_point(MODE_CLUSTER, 48'sh8000, -48'sh8000, 48'sh18000);
    send_point(MODE_CLUSTER, 48'sh7FFF, -48'sh8001, 48'sh17FFF);
    // A rounded cell one above a stored cell welds to it through the neighbour search.
    send_point(MODE_EXACT, 5 * ONE_UNIT, 5 * ONE_UNIT, 5 * ONE_UNIT);
    send_point(MODE_CLUSTER, 6 * ONE_UNIT, 6 * ONE_UNIT, 5 * ONE_UNIT + 48'sh100);
    send_point(MODE_EXACT, -ONE_UNIT, 48'sd1, -48'sd1);
    // A large x coordinate reaches the top of the key range without clamping.
    send_point(MODE_EXACT, 48'sh7FFFF_FFFF, '0, '0);
    write_reg(REG_CELL_SCALE, 32'hFFFF_FFFF);
    send_point(MODE_EXACT, ONE_UNIT, -ONE_UNIT, '0);
    send_point(MODE_CLUSTER, COORD_MIN, 48'sd1, COORD_MAX);
    send_point(MODE_CLUSTER, 48'sd1, 48'sd2, -48'sd1);
    write_reg(REG_CELL_SCALE, 32'd1);
    send_point(MODE_EXACT, COORD_MAX, COORD_MIN, ONE_UNIT);
    send_point(MODE_CLUSTER, COORD_MAX, COORD_MIN, ONE_UNIT);
    // Index base at its top saturates every index.
    write_reg(REG_INDEX_BASE, 32'h00FF_FFFF);
    send_point(MODE_EXACT, '0, '0, '0);
    send_point(MODE_CLUSTER, COORD_MAX, '0, COORD_MIN);
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
    send_point(MODE_EXACT, COORD_MAX, COORD_MIN, COORD_MAX);
    write_reg(REG_INDEX_BASE, 32'd0);
    write_reg(REG_CELL_SCALE, 32'd65536);
    send_point(MODE_EXACT, 48'sd1, 48'sd1, 48'sd1);
  endtask

  // Mostly clustered points with random content, with a share of fully random noise.
  task automatic test_random_welds(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        send_point(1'($urandom()), random_coord(), random_coord(), random_coord());
      end else begin
        send_point(1'($urandom()), cluster_coord(), cluster_coord(), cluster_coord());
      end
    end
  endtask

  // The receiver stalls for a long stretch while points keep coming, then the
  // sender stops until the block has drained completely; a batch of exact points follows.
  task automatic test_backpressure();
    wait_idle();
    hold_off_cycles = 4000;
    for (int i = 0; i < 12; i++) begin
      send_point(MODE_CLUSTER, cluster_coord(), cluster_coord(), cluster_coord());
    end
    wait_idle();
    for (int i = 0; i < 12; i++) begin
      send_point(MODE_EXACT, cluster_coord(), cluster_coord(), cluster_coord());
    end
  endtask

  // Distinct cells fill the table; later new cells report a full table while
  // known cells still weld.
  task automatic test_table_full();
    int fill;
    write_reg(REG_CELL_SCALE, 32'd65536);
    fill = DEPTH - stored_keys.size();
    for (int i = 0; i < fill + 8; i++) begin
      send_point(MODE_EXACT, (48'sd300000 + i) * ONE_UNIT, -48'sd300000 * ONE_UNIT,
                 48'sd12345 * ONE_UNIT);
    end
    send_point(MODE_EXACT, '0, '0, '0);
    send_point(MODE_CLUSTER, random_coord(), random_coord(), random_coord());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    send_idle_pct = 8;
    recv_idle_pct = 51;
    test_random_welds(250);
    write_reg(REG_INDEX_BASE, {8'd0, 24'($urandom())});
    write_reg(REG_CELL_SCALE, 32'h0000_8000);
    send_idle_pct = 51;
    recv_idle_pct = 8;
    test_random_welds(250);
    write_reg(REG_CELL_SCALE, $urandom());
    test_random_welds(30);
    write_reg(REG_CELL_SCALE, 32'h0003_0000);
    write_reg(REG_INDEX_BASE, 32'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_welds(250);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_table_full();
    wait_idle();
    $display("Sent %0d points, checked %0d results: %0d new entries, %0d full, %0d clamped.",
             points_sent, results_checked, new_entries_seen, full_seen, clamp_seen);
    if (error_count == 0) begin
      $display("grid_point_dedup_table verification clean");
    end else begin
      $display("grid_point_dedup_table verification failed");
    end
    $finish;
  end
endmodule
